// ===== hw/rtl/crc8fp_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the framed speed receiver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package crc8fp_pkg;

	// Frame format and checksum.
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'hA6;
	localparam int         FRAME_W   = 32;

	// Serial divider geometry: the widest dividend is |speed| * 10000, below 2^29.
	localparam int DIV_N     = 29;
	localparam int DIVS_W    = 15;
	localparam int DIV_CNT_W = $clog2(DIV_N + 1);
	localparam int Q1_W      = 29;

	// Fixed-point scale of the intermediate duty fraction.
	localparam logic [DIVS_W-1:0] SCALE_UNIT = DIVS_W'(10000);

	// Scale-down by 10000 as a reciprocal multiplication. The scaled value is a
	// fraction below 10000 times the span (14 + 8 bits); with a shift of 34 the
	// rounded-up reciprocal gives the exact floor for every such value.
	localparam int          SCL_W     = 22;
	localparam int          RCP_W     = SCL_W + 21;
	localparam int          RCP_SHIFT = 34;
	localparam logic [20:0] RCP_MUL   = 21'd1717987;

	// Depth of the frame queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Register map indexes (byte address / 4).
	localparam logic [1:0] REG_PWM_MIN    = 2'd0;
	localparam logic [1:0] REG_PWM_MAX    = 2'd1;
	localparam logic [1:0] REG_FULL_SPEED = 2'd2;

	// Register reset values.
	localparam logic [7:0]  PWM_MIN_RST    = 8'd20;
	localparam logic [7:0]  PWM_MAX_RST    = 8'd231;
	localparam logic [14:0] FULL_SPEED_RST = 15'd7580;

	// Request to and answer from the divider.
	typedef struct packed {
		logic              start;
		logic [DIV_N-1:0]  dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_N-1:0] quotient;
	} div_rsp_t;

	// One byte of the MSB-first CRC-8 with initial value handled by the caller.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			if (c[7] != b[k]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/crc8fp_front.sv =====
// Front part: hunts for the sync byte, collects a frame and checks its CRC-8.
// Pushes each good frame into the queue. Depends on crc8fp_pkg.
`timescale 1ns / 1ps

module crc8fp_front
	import crc8fp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               queue_full,
	output logic               push,
	output logic [FRAME_W-1:0] push_frame
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_D0    = 3'd1;
	localparam logic [2:0] PH_D1    = 3'd2;
	localparam logic [2:0] PH_D2    = 3'd3;
	localparam logic [2:0] PH_D3    = 3'd4;
	localparam logic [2:0] PH_CHECK = 3'd5;

	logic [2:0] phase_q;
	logic [7:0] crc_q;
	logic [7:0] data0_q, data1_q, data2_q, data3_q;
	logic       accept;

	// Only the check byte may have to wait for room in the queue.
	assign in_ready   = !((phase_q == PH_CHECK) && queue_full);
	assign accept     = in_valid && in_ready;
	assign push       = accept && (phase_q == PH_CHECK) && (in_byte == crc_q);
	assign push_frame = {data3_q, data2_q, data1_q, data0_q};

	// Frame phase and running CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= 8'd0;
		end else if (accept) begin
			case (phase_q)
				PH_D0: begin
					crc_q   <= crc8_byte(crc_q, in_byte);
					phase_q <= PH_D1;
				end
				PH_D1: begin
					crc_q   <= crc8_byte(crc_q, in_byte);
					phase_q <= PH_D2;
				end
				PH_D2: begin
					crc_q   <= crc8_byte(crc_q, in_byte);
					phase_q <= PH_D3;
				end
				PH_D3: begin
					crc_q   <= crc8_byte(crc_q, in_byte);
					phase_q <= PH_CHECK;
				end
				PH_CHECK: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					// Hunting; unused codes behave the same way.
					if (in_byte == SYNC_BYTE) begin
						phase_q <= PH_D0;
						crc_q   <= 8'd0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	// Data bytes of the frame being collected.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_D0:   data0_q <= in_byte;
				PH_D1:   data1_q <= in_byte;
				PH_D2:   data2_q <= in_byte;
				PH_D3:   data3_q <= in_byte;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/crc8fp_queue.sv =====
// Short frame queue between the front and the back part.
// Depends on crc8fp_pkg for the frame width.
`timescale 1ns / 1ps

module crc8fp_queue
	import crc8fp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [FRAME_W-1:0] push_frame,
	input  logic               pop,
	output logic [FRAME_W-1:0] pop_frame,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [FRAME_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop_frame = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

// ===== hw/rtl/crc8fp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the division by full_speed.
// Depends on crc8fp_pkg for widths and the request/answer structs.
`timescale 1ns / 1ps

module crc8fp_div
	import crc8fp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_N-1:0]     quo_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVS_W:0]      trial;
	logic [DIVS_W:0]      diff;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try to subtract.
	assign trial = {rem_q, quo_q[DIV_N-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits replace dividend bits from the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIV_N-2:0], fits};
		end
	end

endmodule

// ===== hw/rtl/crc8fp_back.sv =====
// Back part: turns each queued frame into direction bits and duty values.
// Depends on crc8fp_pkg and drives the divider crc8fp_div.
`timescale 1ns / 1ps

module crc8fp_back
	import crc8fp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         pwm_min,
	input  logic [7:0]         pwm_max,
	input  logic [14:0]        full_speed,
	input  logic               queue_empty,
	input  logic [FRAME_W-1:0] queue_frame,
	output logic               pop,
	output div_req_t           div_req,
	input  div_rsp_t           div_rsp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               dir_right,
	output logic               dir_left,
	output logic [7:0]         duty_right,
	output logic [7:0]         duty_left
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_GO1  = 3'd2;
	localparam logic [2:0] S_DIV1 = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_RCP  = 3'd5;
	localparam logic [2:0] S_OFS  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]         state_q;
	logic               side_q;
	logic [FRAME_W-1:0] frame_q;
	logic [DIV_N-1:0]   prod_q;
	logic [Q1_W-1:0]    q1_q;
	logic               sat_q;
	logic [SCL_W-1:0]   scaled_q;
	logic [7:0]         q2_q;
	logic               dir_r_q, dir_l_q;
	logic [7:0]         duty_r_q, duty_l_q;
	logic               out_valid_q;
	logic               load_out;

	logic [15:0]        raw;
	logic [16:0]        mag;
	logic [30:0]        prod1;
	logic [SCL_W-1:0]   prod2;
	logic [RCP_W-1:0]   rcp_prod;
	logic [7:0]         span;
	logic [DIVS_W-1:0]  fs_eff;
	logic [8:0]         sum9;
	logic [7:0]         duty;

	// Speed of the current side, little-endian, and its magnitude.
	assign raw   = side_q ? frame_q[31:16] : frame_q[15:0];
	assign mag   = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	assign prod1 = {14'd0, mag} * {16'd0, SCALE_UNIT};

	// Duty span, clamped at zero for inverted bounds; zero full speed acts as one.
	assign span   = (pwm_max >= pwm_min) ? (pwm_max - pwm_min) : 8'd0;
	assign fs_eff = (full_speed == 15'd0) ? DIVS_W'(1) : DIVS_W'(full_speed);

	// A fraction of 10000 or more already reaches the full span and saturates, so
	// only its low 14 bits are scaled; the divide by 10000 is a reciprocal multiply.
	assign prod2    = {8'd0, q1_q[13:0]} * {14'd0, span};
	assign rcp_prod = RCP_W'(scaled_q) * RCP_W'(RCP_MUL);

	// Offset and saturation of the final quotient.
	assign sum9 = {1'b0, q2_q} + {1'b0, pwm_min};
	assign duty = (sat_q || (sum9 > {1'b0, pwm_max})) ? pwm_max : sum9[7:0];

	assign pop = (state_q == S_IDLE) && !queue_empty;

	assign div_req.start    = (state_q == S_GO1);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = fs_eff;

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer over the two sides of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			side_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!queue_empty) begin
						side_q  <= 1'b0;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_GO1;
				S_GO1:  state_q <= S_DIV1;
				S_DIV1: begin
					if (div_rsp.done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: state_q <= S_RCP;
				S_RCP:  state_q <= S_OFS;
				S_OFS: begin
					if (side_q) begin
						state_q <= S_DONE;
					end else begin
						side_q  <= 1'b1;
						state_q <= S_MUL1;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= queue_frame;
		end
		if (state_q == S_MUL1) begin
			prod_q <= DIV_N'(prod1);
			if (side_q) begin
				dir_l_q <= raw[15];
			end else begin
				dir_r_q <= raw[15];
			end
		end
		if ((state_q == S_DIV1) && div_rsp.done) begin
			q1_q <= div_rsp.quotient[Q1_W-1:0];
		end
		if (state_q == S_MUL2) begin
			sat_q    <= (q1_q >= Q1_W'(SCALE_UNIT));
			scaled_q <= prod2;
		end
		if (state_q == S_RCP) begin
			q2_q <= rcp_prod[RCP_SHIFT +: 8];
		end
		if (state_q == S_OFS) begin
			if (side_q) begin
				duty_l_q <= duty;
			end else begin
				duty_r_q <= duty;
			end
		end
	end

	// Output register: holds a finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dir_right  <= dir_r_q;
			dir_left   <= dir_l_q;
			duty_right <= duty_r_q;
			duty_left  <= duty_l_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/crc8_framed_dual_speed_to_pwm.sv =====
// Flow: a frame waits in the queue until the back part is idle; each side then runs a multiply by 10000,
// a serial division by full_speed, a span multiply and a reciprocal multiply, and the result is offered
// once the output register is free. Throughput: the front takes one byte per cycle and holds a check
// byte only while the queue is full; the back finishes a frame before it pops the next, and QUEUE_DEPTH
// frames plus the output register absorb bursts. Reset: arst_n clears the frame phase, CRC, queue and
// result valid at once and loads the register defaults (pwm_min 20, pwm_max 231, full_speed 7580).
`timescale 1ns / 1ps

module crc8_framed_dual_speed_to_pwm
	import crc8fp_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Received bytes.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Results.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] dir_right, [1] dir_left,
	                                    // [9:2] duty_right, [17:10] duty_left, [23:18] zero
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]         pwm_min_q;
	logic [7:0]         pwm_max_q;
	logic [14:0]        full_speed_q;
	logic               cfg_write;

	logic               push, pop, queue_full, queue_empty;
	logic [FRAME_W-1:0] push_frame, pop_frame;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic               dir_right, dir_left;
	logic [7:0]         duty_right, duty_left;

	// Register port: zero wait states.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_min_q    <= PWM_MIN_RST;
			pwm_max_q    <= PWM_MAX_RST;
			full_speed_q <= FULL_SPEED_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_PWM_MIN:    pwm_min_q    <= pwdata[7:0];
				REG_PWM_MAX:    pwm_max_q    <= pwdata[7:0];
				REG_FULL_SPEED: full_speed_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PWM_MIN:    prdata = {24'd0, pwm_min_q};
			REG_PWM_MAX:    prdata = {24'd0, pwm_max_q};
			REG_FULL_SPEED: prdata = {17'd0, full_speed_q};
			default:        prdata = 32'd0;
		endcase
	end

	crc8fp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.queue_full (queue_full),
		.push       (push),
		.push_frame (push_frame)
	);

	crc8fp_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.full       (queue_full),
		.empty      (queue_empty)
	);

	crc8fp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	crc8fp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pwm_min     (pwm_min_q),
		.pwm_max     (pwm_max_q),
		.full_speed  (full_speed_q),
		.queue_empty (queue_empty),
		.queue_frame (pop_frame),
		.pop         (pop),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.dir_right   (dir_right),
		.dir_left    (dir_left),
		.duty_right  (duty_right),
		.duty_left   (duty_left)
	);

	assign m_axis_tdata = {6'd0, duty_left, duty_right, dir_left, dir_right};

endmodule

// ===== dv/tb_crc8_framed_dual_speed_to_pwm.sv =====
// Self-checking testbench for crc8_framed_dual_speed_to_pwm: sends sync-framed speed commands
// over the byte stream and checks every duty result against an in-bench predictor.
// Depends on crc8fp_pkg and the crc8_framed_dual_speed_to_pwm top level.
`timescale 1ns / 1ps

module tb_crc8_framed_dual_speed_to_pwm;
	import crc8fp_pkg::*;

	// Position of the predictor inside a frame.
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_DATA0 = 3'd1,
		PH_DATA1 = 3'd2,
		PH_DATA2 = 3'd3,
		PH_DATA3 = 3'd4,
		PH_CHECK = 3'd5
	} frame_phase_t;

	// One motor command as it sits in m_axis_tdata[17:0].
	typedef struct packed {
		logic [7:0] duty_left;
		logic [7:0] duty_right;
		logic       dir_left;
		logic       dir_right;
	} motor_cmd_t;

	// Frame predictor and queue of motor commands still to come out of the block.
	class motor_cmd_scoreboard;
		logic [7:0]   pwm_min;
		logic [7:0]   pwm_max;
		logic [14:0]  full_speed;
		frame_phase_t phase;
		logic [7:0]   frame_bytes[4];
		logic [7:0]   crc;
		motor_cmd_t   pending_cmds[$];
		int unsigned  mismatches;

		function new();
			pwm_min    = PWM_MIN_RST;
			pwm_max    = PWM_MAX_RST;
			full_speed = FULL_SPEED_RST;
			phase      = PH_HUNT;
			crc        = 8'h00;
			mismatches = 0;
			foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
		endfunction

		// MSB-first CRC-8 over one byte.
		static function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
			logic [7:0] r;
			r = c;
			for (int k = 7; k >= 0; k--) begin
				if (r[7] != b[k]) begin
					r = {r[6:0], 1'b0} ^ CRC_POLY;
				end else begin
					r = {r[6:0], 1'b0};
				end
			end
			return r;
		endfunction

		// Signed little-endian speed to direction and clamped duty, without any wrap.
		function void speed_to_duty(input logic [7:0] lo, input logic [7:0] hi,
			output logic dir, output logic [7:0] duty);
			logic [15:0]     raw;
			longint unsigned mag, fs, span, q, d;
			raw  = {hi, lo};
			dir  = raw[15];
			mag  = raw[15] ? (64'd65536 - 64'(raw)) : 64'(raw);
			fs   = (full_speed == 15'd0) ? 64'd1 : 64'(full_speed);
			span = (pwm_max >= pwm_min) ? 64'(pwm_max - pwm_min) : 64'd0;
			q    = (mag * 64'd10000) / fs;
			d    = (q * span) / 64'd10000 + 64'(pwm_min);
			if (d > 64'(pwm_max)) begin
				d = 64'(pwm_max);
			end
			duty = d[7:0];
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_PWM_MIN:    pwm_min    = val[7:0];
				REG_PWM_MAX:    pwm_max    = val[7:0];
				REG_FULL_SPEED: full_speed = val[14:0];
				default: ;
			endcase
		endfunction

		// Advance the frame state by one accepted byte.
		function void take_byte(logic [7:0] b);
			motor_cmd_t cmd;
			case (phase)
				PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3: begin
					frame_bytes[int'(phase) - 1] = b;
					crc   = crc_update(crc, b);
					phase = frame_phase_t'(phase + 3'd1);
				end
				PH_CHECK: begin
					phase = PH_HUNT;
					if (b == crc) begin
						speed_to_duty(frame_bytes[0], frame_bytes[1], cmd.dir_right,
							cmd.duty_right);
						speed_to_duty(frame_bytes[2], frame_bytes[3], cmd.dir_left,
							cmd.duty_left);
						pending_cmds.push_back(cmd);
					end
				end
				default: begin
					if (b == SYNC_BYTE) begin
						phase = PH_DATA0;
						crc   = 8'h00;
					end else begin
						phase = PH_HUNT;
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one result item with the oldest pending command.
		task check_result(logic [23:0] word);
			motor_cmd_t got, want;
			got = word[17:0];
			if (word[23:18] != 6'd0) begin
				report_mismatch($sformatf("padding bits set: %h", word[23:18]));
			end
			if (pending_cmds.size() == 0) begin
				report_mismatch($sformatf("result %h with no command pending", word));
			end else begin
				want = pending_cmds.pop_front();
				if (got.dir_right != want.dir_right)
					report_mismatch($sformatf("dir_right %0d, want %0d",
						got.dir_right, want.dir_right));
				if (got.dir_left != want.dir_left)
					report_mismatch($sformatf("dir_left %0d, want %0d",
						got.dir_left, want.dir_left));
				if (got.duty_right != want.duty_right)
					report_mismatch($sformatf("duty_right %0d, want %0d",
						got.duty_right, want.duty_right));
				if (got.duty_left != want.duty_left)
					report_mismatch($sformatf("duty_left %0d, want %0d",
						got.duty_left, want.duty_left));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // [0] dir_right, [1] dir_left, [9:2] duty_right,
	                                     // [17:10] duty_left, [23:18] zero
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// Flags from the stimulus process to the receiver and to send_byte.
	logic        hold_req = 1'b0;
	logic        recv_no_idle = 1'b0;
	logic        send_no_idle = 1'b0;

	// Receiver-only bookkeeping.
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;

	int          bytes_sent = 0;
	motor_cmd_scoreboard sb = new();

	crc8_framed_dual_speed_to_pwm i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: check accepted results, then decide readiness for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!recv_no_idle && $urandom_range(0, 3) == 0) begin
					stall_left = gap_len();
				end
			end
		end
	end

	// Offer one byte after an optional gap and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_no_idle ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	// Sync, two little-endian speeds and the check byte, optionally spoiled.
	task automatic send_frame(input logic [15:0] right, input logic [15:0] left,
		input bit spoil);
		logic [7:0] body[4];
		logic [7:0] chk;
		body = '{right[7:0], right[15:8], left[7:0], left[15:8]};
		chk  = 8'h00;
		foreach (body[i]) chk = motor_cmd_scoreboard::crc_update(chk, body[i]);
		if (spoil) begin
			chk = chk ^ 8'($urandom_range(1, 255));
		end
		send_byte(SYNC_BYTE);
		foreach (body[i]) send_byte(body[i]);
		send_byte(chk);
	endtask

	// Speeds: extremes, values around the full-scale point, or anything.
	function automatic logic [15:0] pick_speed();
		int r, m;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 4))
				0: return 16'h0000;
				1: return 16'h7FFF;
				2: return 16'h8000;
				3: return 16'hFFFF;
				default: return 16'h0001;
			endcase
		end
		if (r < 50) begin
			m = $urandom_range(0, int'(sb.full_speed) + int'(sb.full_speed) / 8 + 2);
			if (m > 32767) m = 32767;
			return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
		end
		return 16'($urandom);
	endfunction

	// Mostly good frames, some spoiled ones, loose bytes and cut-off frames.
	task automatic random_burst(input int n);
		int target, r, cut;
		target = bytes_sent + n;
		while (bytes_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_frame(pick_speed(), pick_speed(), 1'b0);
			end else if (r < 85) begin
				send_frame(pick_speed(), pick_speed(), 1'b1);
			end else if (r < 93) begin
				send_byte(8'($urandom));
			end else begin
				cut = $urandom_range(0, 4);
				send_byte(SYNC_BYTE);
				repeat (cut) send_byte(8'($urandom));
			end
		end
	endtask

	// Stop sending, let every result drain and the back part go quiet.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// Register write with a setup and an access phase; the register updates at the access edge, then the bus idles.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_duty_range(input int lo, input int hi, input int fs);
		reg_write(REG_PWM_MIN, 32'(lo));
		reg_write(REG_PWM_MAX, 32'(hi));
		reg_write(REG_FULL_SPEED, 32'(fs));
	endtask

	// Main stimulus.
	initial begin
		int lo, hi;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset settings.
		send_byte(8'h00);
		send_byte(8'hFE);
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(16'hFFFF, 16'hFFFF, 1'b0);
		send_frame(16'h0000, 16'h0000, 1'b1);
		send_frame(16'h0000, 16'h0001, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: set_duty_range(0, 255, 1000);
				1: set_duty_range(20, 231, 32767);
				2: set_duty_range(255, 255, 1000);
				3: set_duty_range(200, 10, 0);
				4: set_duty_range(0, 0, 32767);
				default: begin
					lo = $urandom_range(0, 255);
					hi = $urandom_range(lo, 255);
					set_duty_range(lo, hi, $urandom_range(1000, 32767));
				end
			endcase
			// In phase 1 the receiver holds off for a long stretch while bytes keep coming; in phase 2 neither side idles.
			if (ph == 1) begin
				hold_req     <= 1'b1;
				send_no_idle <= 1'b1;
			end else if (ph == 2) begin
				send_no_idle <= 1'b1;
				recv_no_idle <= 1'b1;
			end else begin
				send_no_idle <= 1'b0;
				recv_no_idle <= 1'b0;
			end
			@(posedge clk);
			random_burst(112);
		end

		wait_idle();
		if (sb.mismatches == 0) begin
			$display("tb_crc8_framed_dual_speed_to_pwm: done, clean");
		end else begin
			$display("tb_crc8_framed_dual_speed_to_pwm: done, errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20ms;
		$display("tb_crc8_framed_dual_speed_to_pwm: done, errors");
		$finish;
	end

endmodule
